/* hdl/assert_macros.svh */
// Assertion helpers used by the euler_to_rotation_matrix_core RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Implication checked on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed: label");
// Condition that must never hold outside reset.
`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("assertion failed: label");
`else
`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)
`endif

`endif

/* hdl/e2r_pkg.sv */
`default_nettype none
package e2r_pkg;

   localparam int ANGLE_WIDTH_DEF = 16;
   localparam int ELEM_WIDTH_DEF  = 16;

   // internal formats: angles with 29 fraction bits, trig with 30
   localparam int CORDIC_STEPS = 30;
   localparam int TW = 33;   // sin / cos width
   localparam int ZW = 34;   // angle accumulator width
   localparam int PW = 66;   // full product width

   localparam logic signed [ZW-1:0] PI_Q29      = 34'sd1686629713;
   localparam logic signed [ZW-1:0] HALF_PI_Q29 = 34'sd843314856;
   localparam logic signed [TW-1:0] GAIN_Q30    = 33'sd652032874;

   typedef struct packed {
      logic signed [TW-1:0] sin_v;
      logic signed [TW-1:0] cos_v;
   } trig_type;

   // arctangent of 2^-i with 29 fraction bits
   function automatic logic signed [ZW-1:0] atan_q29(input int i);
      logic signed [ZW-1:0] r;
      unique case (i)
         0: r = 34'sd421657428;
         1: r = 34'sd248918915;
         2: r = 34'sd131521918;
         3: r = 34'sd66762579;
         4: r = 34'sd33510843;
         5: r = 34'sd16771758;
         6: r = 34'sd8387925;
         7: r = 34'sd4194219;
         8: r = 34'sd2097141;
         9: r = 34'sd1048575;
         default: r = ZW'(64'sd1 <<< (29 - i));
      endcase
      return r;
   endfunction

   // product of two Q30 values, rounded back to Q30
   function automatic logic signed [TW-1:0] mul30(input logic signed [TW-1:0] a,
                                                  input logic signed [TW-1:0] b);
      logic signed [PW-1:0] p;
      p = PW'(a) * PW'(b) + (PW'(1) <<< 29);
      return p[TW+29:30];
   endfunction

endpackage
`default_nettype wire

/* hdl/euler_to_rotation_matrix_core.sv */
// Pipeline from an accepted req beat to its rsp beat: reduction, 30 CORDIC
// steps, sign fix, two multiply stages, sum stage.
// Throughput: one beat per cycle; the whole pipeline holds while rsp is stalled.
// Reset: synchronous, active high; clears the valid bits only, no datapath state.
`default_nettype none
`include "assert_macros.svh"
module euler_to_rotation_matrix_core #(
   parameter int ANGLE_WIDTH = e2r_pkg::ANGLE_WIDTH_DEF,
   parameter int ELEM_WIDTH  = e2r_pkg::ELEM_WIDTH_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   output logic      req_tready,
   // roll_angle, pitch_angle, yaw_angle from bit 0 up, zero padded
   input  wire logic [((3*ANGLE_WIDTH+7)/8)*8-1:0] req_tdata,
   output logic      rsp_tvalid,
   input  wire logic rsp_tready,
   // elem_00, elem_01, elem_02, elem_10, elem_11, elem_12, elem_20, elem_21,
   // elem_22 from bit 0 up, zero padded
   output logic [((9*ELEM_WIDTH+7)/8)*8-1:0] rsp_tdata
);
   localparam logic signed [ELEM_WIDTH-1:0] ELEM_ONE = ELEM_WIDTH'(1) <<< (ELEM_WIDTH - 2);
   localparam logic signed [e2r_pkg::TW-1:0] TRIG_BOUND = 33'sd1200000000;

   logic                   ce;
   logic [ANGLE_WIDTH-1:0] angle [3];
   logic                   trig_valid;
   e2r_pkg::trig_type      trig [3];
   logic [ELEM_WIDTH-1:0]  elem [9];
   logic                   trig_out_of_range;

   // global pipeline advance
   assign ce         = !rsp_tvalid || rsp_tready;
   assign req_tready = ce;

   for (genvar k = 0; k < 3; k++) begin : g_ang
      assign angle[k] = req_tdata[k*ANGLE_WIDTH +: ANGLE_WIDTH];
   end

   e2r_sincos #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_sincos (
      .clock     (clock),
      .reset     (reset),
      .ce        (ce),
      .in_valid  (req_tvalid),
      .angle     (angle),
      .out_valid (trig_valid),
      .trig      (trig)
   );

   e2r_matrix #(.ELEM_WIDTH(ELEM_WIDTH)) u_matrix (
      .clock     (clock),
      .reset     (reset),
      .ce        (ce),
      .in_valid  (trig_valid),
      .t_roll    (trig[0]),
      .t_pitch   (trig[1]),
      .t_yaw     (trig[2]),
      .out_valid (rsp_tvalid),
      .elem      (elem)
   );

   // pack result beat
   always_comb begin
      rsp_tdata = '0;
      for (int k = 0; k < 9; k++) rsp_tdata[k*ELEM_WIDTH +: ELEM_WIDTH] = elem[k];
   end

   assign trig_out_of_range = (trig[0].sin_v > TRIG_BOUND) || (trig[0].sin_v < -TRIG_BOUND);

   // a stalled output holds the pipeline
   `ASSERT_CLK(a_stall_holds, clock, reset, (rsp_tvalid && !rsp_tready) |-> !req_tready)
   // elem_00 of a result never exceeds plus one
   `ASSERT_NEVER(a_elem_range, clock, reset, rsp_tvalid && ($signed(elem[0]) > ELEM_ONE))
   // the roll sine of a valid trig beat is bounded in magnitude
   `ASSERT_NEVER(a_trig_range, clock, reset, trig_valid && trig_out_of_range)

endmodule
`default_nettype wire

/* hdl/e2r_sincos.sv */
`default_nettype none
// Three-lane pipelined CORDIC: one reduction stage, one stage per step,
// one sign-fix stage.
module e2r_sincos #(
   parameter int ANGLE_WIDTH = e2r_pkg::ANGLE_WIDTH_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   ce,
   input  wire logic                   in_valid,
   input  wire logic [ANGLE_WIDTH-1:0] angle [3],
   output logic                        out_valid,
   output e2r_pkg::trig_type           trig [3]
);
   localparam int N  = e2r_pkg::CORDIC_STEPS;
   localparam int TW = e2r_pkg::TW;
   localparam int ZW = e2r_pkg::ZW;

   logic                 vld_ff [N+2];
   logic signed [TW-1:0] x_ff   [N+1][3];
   logic signed [TW-1:0] y_ff   [N+1][3];
   logic signed [ZW-1:0] z_ff   [N+1][3];
   logic                 neg_ff [N+1][3];
   e2r_pkg::trig_type    trig_ff [3];

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < N + 2; k++) vld_ff[k] <= 1'b0;
      end else if (ce) begin
         vld_ff[0] <= in_valid;
         for (int k = 1; k < N + 2; k++) vld_ff[k] <= vld_ff[k-1];
      end
   end

   for (genvar l = 0; l < 3; l++) begin : g_lane
      logic signed [ZW-1:0] a_in;
      assign a_in = ZW'($signed({angle[l], {(32-ANGLE_WIDTH){1'b0}}}));

      // quadrant reduction into [-pi/2, pi/2]
      always_ff @(posedge clock) begin
         if (ce) begin
            x_ff[0][l] <= e2r_pkg::GAIN_Q30;
            y_ff[0][l] <= '0;
            if (a_in > e2r_pkg::HALF_PI_Q29) begin
               z_ff[0][l]   <= a_in - e2r_pkg::PI_Q29;
               neg_ff[0][l] <= 1'b1;
            end else if (a_in < -e2r_pkg::HALF_PI_Q29) begin
               z_ff[0][l]   <= a_in + e2r_pkg::PI_Q29;
               neg_ff[0][l] <= 1'b1;
            end else begin
               z_ff[0][l]   <= a_in;
               neg_ff[0][l] <= 1'b0;
            end
         end
      end

      // one rotation step per stage
      for (genvar s = 0; s < N; s++) begin : g_step
         localparam logic signed [ZW-1:0] ATAN = e2r_pkg::atan_q29(s);
         always_ff @(posedge clock) begin
            if (ce) begin
               neg_ff[s+1][l] <= neg_ff[s][l];
               if (z_ff[s][l] >= 0) begin
                  x_ff[s+1][l] <= x_ff[s][l] - (y_ff[s][l] >>> s);
                  y_ff[s+1][l] <= y_ff[s][l] + (x_ff[s][l] >>> s);
                  z_ff[s+1][l] <= z_ff[s][l] - ATAN;
               end else begin
                  x_ff[s+1][l] <= x_ff[s][l] + (y_ff[s][l] >>> s);
                  y_ff[s+1][l] <= y_ff[s][l] - (x_ff[s][l] >>> s);
                  z_ff[s+1][l] <= z_ff[s][l] + ATAN;
               end
            end
         end
      end

      // undo the half-turn of the reduction
      always_ff @(posedge clock) begin
         if (ce) begin
            trig_ff[l].sin_v <= neg_ff[N][l] ? -y_ff[N][l] : y_ff[N][l];
            trig_ff[l].cos_v <= neg_ff[N][l] ? -x_ff[N][l] : x_ff[N][l];
         end
      end
      assign trig[l] = trig_ff[l];
   end

   assign out_valid = vld_ff[N+1];

endmodule
`default_nettype wire

/* hdl/e2r_matrix.sv */
`default_nettype none
// Matrix products: first products, second products, sum/round/saturate.
module e2r_matrix #(
   parameter int ELEM_WIDTH = e2r_pkg::ELEM_WIDTH_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              ce,
   input  wire logic              in_valid,
   input  e2r_pkg::trig_type      t_roll,
   input  e2r_pkg::trig_type      t_pitch,
   input  e2r_pkg::trig_type      t_yaw,
   output logic                   out_valid,
   output logic [ELEM_WIDTH-1:0]  elem [9]
);
   localparam int TW  = e2r_pkg::TW;
   localparam int SW  = TW + 2;
   localparam int S   = 32 - ELEM_WIDTH;
   localparam logic signed [SW-1:0] RND = (S > 0) ? (SW'(1) <<< (S > 0 ? S - 1 : 0)) : '0;
   localparam logic signed [SW-1:0] LIM = SW'(1) <<< (ELEM_WIDTH - 2);

   function automatic logic [ELEM_WIDTH-1:0] to_elem(input logic signed [SW-1:0] v);
      logic signed [SW-1:0] r;
      r = (v + RND) >>> S;
      if (r > LIM) r = LIM;
      if (r < -LIM) r = -LIM;
      return r[ELEM_WIDTH-1:0];
   endfunction

   logic [2:0] vld_ff;

   // stage 1
   logic signed [TW-1:0] sfst_ff, cfst_ff, cp1_ff, sp1_ff, st1_ff;
   logic signed [TW-1:0] p00_ff, cfsp_ff, sfsp_ff, p10_ff, cfcp_ff, sfcp_ff, p21_ff, p22_ff;
   // stage 2
   logic signed [TW-1:0] q01_ff, q02_ff, q11_ff, q12_ff, st2_ff;
   logic signed [TW-1:0] p00b_ff, cfsp2_ff, sfsp2_ff, p10b_ff, cfcp2_ff, sfcp2_ff;
   logic signed [TW-1:0] p21b_ff, p22b_ff;
   // stage 3
   logic [ELEM_WIDTH-1:0] elem_ff [9];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (ce) begin
         vld_ff <= {vld_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         // products of the angle terms
         sfst_ff <= e2r_pkg::mul30(t_roll.sin_v, t_pitch.sin_v);
         cfst_ff <= e2r_pkg::mul30(t_roll.cos_v, t_pitch.sin_v);
         cp1_ff  <= t_yaw.cos_v;
         sp1_ff  <= t_yaw.sin_v;
         st1_ff  <= t_pitch.sin_v;
         p00_ff  <= e2r_pkg::mul30(t_pitch.cos_v, t_yaw.cos_v);
         cfsp_ff <= e2r_pkg::mul30(t_roll.cos_v, t_yaw.sin_v);
         sfsp_ff <= e2r_pkg::mul30(t_roll.sin_v, t_yaw.sin_v);
         p10_ff  <= e2r_pkg::mul30(t_pitch.cos_v, t_yaw.sin_v);
         cfcp_ff <= e2r_pkg::mul30(t_roll.cos_v, t_yaw.cos_v);
         sfcp_ff <= e2r_pkg::mul30(t_roll.sin_v, t_yaw.cos_v);
         p21_ff  <= e2r_pkg::mul30(t_roll.sin_v, t_pitch.cos_v);
         p22_ff  <= e2r_pkg::mul30(t_roll.cos_v, t_pitch.cos_v);

         // second-level products
         q01_ff   <= e2r_pkg::mul30(sfst_ff, cp1_ff);
         q02_ff   <= e2r_pkg::mul30(cfst_ff, cp1_ff);
         q11_ff   <= e2r_pkg::mul30(sfst_ff, sp1_ff);
         q12_ff   <= e2r_pkg::mul30(cfst_ff, sp1_ff);
         st2_ff   <= st1_ff;
         p00b_ff  <= p00_ff;
         cfsp2_ff <= cfsp_ff;
         sfsp2_ff <= sfsp_ff;
         p10b_ff  <= p10_ff;
         cfcp2_ff <= cfcp_ff;
         sfcp2_ff <= sfcp_ff;
         p21b_ff  <= p21_ff;
         p22b_ff  <= p22_ff;

         // sums, rounding, saturation
         elem_ff[0] <= to_elem(SW'(p00b_ff));
         elem_ff[1] <= to_elem(SW'(q01_ff) - SW'(cfsp2_ff));
         elem_ff[2] <= to_elem(SW'(sfsp2_ff) + SW'(q02_ff));
         elem_ff[3] <= to_elem(SW'(p10b_ff));
         elem_ff[4] <= to_elem(SW'(cfcp2_ff) + SW'(q11_ff));
         elem_ff[5] <= to_elem(SW'(q12_ff) - SW'(sfcp2_ff));
         elem_ff[6] <= to_elem(-SW'(st2_ff));
         elem_ff[7] <= to_elem(SW'(p21b_ff));
         elem_ff[8] <= to_elem(SW'(p22b_ff));
      end
   end

   assign out_valid = vld_ff[2];
   assign elem      = elem_ff;

endmodule
`default_nettype wire

/* tb/sv/euler_to_rotation_matrix_core_tb.sv */
`timescale 1ns / 100ps
`default_nettype none
module euler_to_rotation_matrix_core_tb;

   localparam int AW = 16;
   localparam int EW = 16;
   localparam int REQ_W = ((3*AW+7)/8)*8;
   localparam int RSP_W = ((9*EW+7)/8)*8;
   localparam int LATENCY = 35;
   localparam longint CYCLE_LIMIT = 400000;

   // trig pair with 30 fraction bits
   typedef struct {
      longint sn;
      longint cs;
   } sincos_type;

   typedef logic [RSP_W-1:0] matrix_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   // roll_angle, pitch_angle, yaw_angle from bit 0 up
   logic [REQ_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   // elem_00 .. elem_22 row by row from bit 0 up
   logic [RSP_W-1:0] rsp_tdata;

   matrix_type expected_matrices[$];
   int mismatches = 0;
   longint cycle_count = 0;
   bit hold_rsp = 1'b0;
   int hold_cycles = 0;

   euler_to_rotation_matrix_core dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------- predictor ----------------
   function automatic longint fshift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint atan_step(int i);
      longint tbl[10] = '{421657428, 248918915, 131521918, 66762579, 33510843,
                          16771758, 8387925, 4194219, 2097141, 1048575};
      if (i < 10) return tbl[i];
      return 64'sd1 <<< (29 - i);
   endfunction

   function automatic sincos_type cordic_sincos(logic [AW-1:0] raw);
      longint a, x, y, z, dx, dy;
      bit flip;
      sincos_type r;
      a = longint'($signed(raw)) <<< (32 - AW);
      flip = 1'b0;
      if (a > 843314856) begin
         a -= 1686629713; flip = 1'b1;
      end else if (a < -843314856) begin
         a += 1686629713; flip = 1'b1;
      end
      x = 652032874; y = 0; z = a;
      for (int i = 0; i < 30; i++) begin
         dx = fshift(y, i);
         dy = fshift(x, i);
         if (z >= 0) begin
            x -= dx; y += dy; z -= atan_step(i);
         end else begin
            x += dx; y -= dy; z += atan_step(i);
         end
      end
      r.sn = flip ? -y : y;
      r.cs = flip ? -x : x;
      return r;
   endfunction

   function automatic longint qmul(longint a, longint b);
      return fshift(a * b + (64'sd1 <<< 29), 30);
   endfunction

   function automatic logic [EW-1:0] sat_elem(longint v);
      longint r, lim;
      lim = 64'sd1 <<< (EW - 2);
      r = (EW < 32) ? fshift(v + (64'sd1 <<< (31 - EW)), 32 - EW) : v;
      if (r > lim) r = lim;
      if (r < -lim) r = -lim;
      return r[EW-1:0];
   endfunction

   function automatic matrix_type predict_matrix(logic [AW-1:0] roll, logic [AW-1:0] pitch,
                                                 logic [AW-1:0] yaw);
      sincos_type f, t, p;
      longint sfst, cfst;
      matrix_type m;
      f = cordic_sincos(roll);
      t = cordic_sincos(pitch);
      p = cordic_sincos(yaw);
      sfst = qmul(f.sn, t.sn);
      cfst = qmul(f.cs, t.sn);
      m = '0;
      m[0*EW +: EW] = sat_elem(qmul(t.cs, p.cs));
      m[1*EW +: EW] = sat_elem(-qmul(f.cs, p.sn) + qmul(sfst, p.cs));
      m[2*EW +: EW] = sat_elem(qmul(f.sn, p.sn) + qmul(cfst, p.cs));
      m[3*EW +: EW] = sat_elem(qmul(t.cs, p.sn));
      m[4*EW +: EW] = sat_elem(qmul(f.cs, p.cs) + qmul(sfst, p.sn));
      m[5*EW +: EW] = sat_elem(-qmul(f.sn, p.cs) + qmul(cfst, p.sn));
      m[6*EW +: EW] = sat_elem(-t.sn);
      m[7*EW +: EW] = sat_elem(qmul(f.sn, t.cs));
      m[8*EW +: EW] = sat_elem(qmul(f.cs, t.cs));
      return m;
   endfunction

   // ---------------- sender ----------------
   int burst_left = 0;

   // tvalid stays high between beats of a burst; it drops only for a gap
   task automatic send_angles(logic [AW-1:0] roll, logic [AW-1:0] pitch,
                              logic [AW-1:0] yaw, bit use_gaps);
      int gap;
      if (use_gaps && burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      if (burst_left > 0) burst_left--;
      req_tvalid <= 1'b1;
      req_tdata <= {yaw, pitch, roll};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_matrices.push_back(predict_matrix(roll, pitch, yaw));
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_matrices.size() != 0) @(posedge clock);
   endtask

   // ---------------- receiver ----------------
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (hold_rsp) begin
         rsp_tready <= 1'b0;
         if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
      end else if (!reset) begin
         // stall roughly one beat in four, with stall-free stretches
         rsp_tready <= (cycle_count[9:8] == 2'b11) ? 1'b1 : ($urandom_range(0, 3) != 0);
      end
   end

   // result checker
   always @(posedge clock) begin
      matrix_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_matrices.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected rsp beat %h", rsp_tdata);
         end else begin
            want = expected_matrices.pop_front();
            for (int e = 0; e < 9; e++) begin
               if (rsp_tdata[e*EW +: EW] !== want[e*EW +: EW]) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("elem %0d%0d: expected %0d actual %0d", e / 3, e % 3,
                              $signed(want[e*EW +: EW]), $signed(rsp_tdata[e*EW +: EW]));
               end
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // ---------------- tests ----------------
   task automatic test_extremes();
      logic [AW-1:0] vals[9] = '{16'h0000, 16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF,
                                 16'd12868, 16'd12869, -16'sd12868, -16'sd12869};
      foreach (vals[i]) send_angles(vals[i], vals[(i+3)%9], vals[(i+6)%9], 1'b0);
      // quadrant edges and saturation corners
      send_angles(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0);
      send_angles(16'h8000, 16'h8000, 16'h8000, 1'b0);
      send_angles(16'd25736, 16'd12868, -16'sd25736, 1'b0);
      send_angles(16'd6434, -16'sd6434, 16'd19302, 1'b0);
      send_angles(16'h5555, 16'hAAAA, 16'h5555, 1'b0);
      send_angles(16'hAAAA, 16'h5555, 16'hAAAA, 1'b0);
      wait_drained();
   endtask

   task automatic test_random(int n);
      for (int k = 0; k < n; k++)
         send_angles(AW'($urandom), AW'($urandom), AW'($urandom), 1'b1);
   endtask

   task automatic test_backpressure();
      // receiver holds off long; sender keeps offering until the pipe fills
      hold_cycles = 120;
      hold_rsp = 1'b1;
      fork
         test_random(80);
         begin
            while (hold_cycles > 0) @(posedge clock);
            hold_rsp = 1'b0;
         end
      join
      wait_drained();
   endtask

   task automatic test_near_half_pi();
      for (int k = 0; k < 60; k++)
         send_angles(AW'(16'd12868 + $urandom_range(0, 6) - 3),
                     AW'(-16'sd12868 + $urandom_range(0, 6) - 3),
                     AW'(16'd25736 + $urandom_range(0, 6) - 3), 1'b1);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_random(400);
      wait_drained();
      test_backpressure();
      test_near_half_pi();
      test_random(360);
      wait_drained();
      repeat (LATENCY + 10) @(posedge clock);
      if (mismatches == 0 && expected_matrices.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end
endmodule
`default_nettype wire
